### sv/alc_pkg.sv
// Package for the associative LRU tag cache: sizes, opcodes, slot entry and
// scan status types shared by the interfaces and all modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alc_pkg;

  localparam int SLOTS      = 8;
  localparam int ADDR_BITS  = 48;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SRC_ADDR_W = 48;
  localparam int KEY_ADDR_W = (ADDR_BITS < SRC_ADDR_W) ? ADDR_BITS : SRC_ADDR_W;
  localparam int DIM_W      = 16;
  localparam int TARGET_W   = 16;
  localparam int STAMP_W    = 64;
  localparam int SLOT_OUT_W = 3;

  localparam logic OP_LOOKUP  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic [KEY_ADDR_W-1:0] addr;
    logic [DIM_W-1:0]      width;
    logic [DIM_W-1:0]      height;
    logic [STAMP_W-1:0]    stamp;
  } slot_entry_t;

  typedef struct packed {
    logic step;   // evaluate the slot now on the read port
    logic first;  // this is slot zero, restart the victim search
  } scan_ctrl_t;

  typedef struct packed {
    logic             hit;           // current slot matches the key
    logic [IDX_W-1:0] victim;        // victim chosen so far
    logic             victim_valid;  // victim slot holds a valid entry
  } scan_status_t;

  // Slot index as reported on the result channel: its low three bits.
  function automatic logic [SLOT_OUT_W-1:0] slot_code(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_OUT_W-1:0] ext;
    ext = {{SLOT_OUT_W{1'b0}}, idx};
    return ext[SLOT_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/alc_if.sv
// Valid/ready channel interfaces for the request and result beats of the
// associative LRU tag cache. Depends on alc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface alc_req_if;
  import alc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [TARGET_W-1:0]   target_id;
  logic [SRC_ADDR_W-1:0] source_address;
  logic [DIM_W-1:0]      image_width;
  logic [DIM_W-1:0]      image_height;

  modport source (output valid, opcode, target_id, source_address, image_width,
                  image_height, input ready);
  modport sink (input valid, opcode, target_id, source_address, image_width,
                image_height, output ready);
endinterface

interface alc_rsp_if;
  import alc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic                  evicted;
  logic                  flushed;

  modport source (output valid, hit, slot_index, evicted, flushed, input ready);
  modport sink (input valid, hit, slot_index, evicted, flushed, output ready);
endinterface

`default_nettype wire

### sv/alc_slot_ram.sv
// Slot store of the tag cache: key and timestamp per slot, one write port and
// one registered read port. Depends on alc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alc_slot_ram
  import alc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire slot_entry_t wr_data,
  input  wire logic [IDX_W-1:0] rd_idx,
  output slot_entry_t      rd_data
);

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

endmodule

`default_nettype wire

### sv/alc_scan.sv
// Shared compare unit of the tag cache: matches one slot per cycle against
// the key and tracks the LRU victim across the scan. Depends on alc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alc_scan
  import alc_pkg::*;
(
  input  wire logic                  clk,
  input  wire scan_ctrl_t            ctrl,
  input  wire logic [IDX_W-1:0]      idx,
  input  wire slot_entry_t           entry,
  input  wire logic                  entry_valid,
  input  wire logic [KEY_ADDR_W-1:0] key_addr,
  input  wire logic [DIM_W-1:0]      key_width,
  input  wire logic [DIM_W-1:0]      key_height,
  output scan_status_t               status
);

  logic [IDX_W-1:0]   victim;
  logic               victim_valid;
  logic [STAMP_W-1:0] victim_stamp;
  logic               take;

  // An empty slot always wins (so the last empty one is kept); among valid
  // slots only a strictly older stamp replaces the current choice.
  assign take = ctrl.first || !entry_valid ||
                (victim_valid && (entry.stamp < victim_stamp));

  always_ff @(posedge clk) begin
    if (ctrl.step && take) begin
      victim       <= idx;
      victim_valid <= entry_valid;
      victim_stamp <= entry.stamp;
    end
  end

  assign status.hit = entry_valid && (entry.addr == key_addr) &&
                      (entry.width == key_width) && (entry.height == key_height);
  assign status.victim       = victim;
  assign status.victim_valid = victim_valid;

endmodule

`default_nettype wire

### sv/assoc_lru_tag_cache.sv
// Top level of the fully associative LRU tag cache: sequencer, valid bits,
// use counter, owner register and result register. Depends on alc_pkg,
// alc_if, alc_slot_ram and alc_scan.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The block keeps SLOTS tag slots keyed by source address, width and height.
// Request beats arrive on req; each produces exactly one result beat on rsp.
// A lookup first drops every slot when the cache is owned by a different
// nonzero target, then walks the slots one per cycle through a single
// compare unit fed by the slot RAM's registered read port. A hit stops the
// walk and refreshes the slot's stamp; a miss fills the last empty slot or
// else the lowest-index slot with the oldest stamp.
// Sequence: a lookup is accepted in the idle state, scans one to SLOTS slots
// through the single read port, writes the chosen slot and then loads the
// result register. A release goes straight from acceptance to loading the
// result register.
// req.ready is high only while the sequencer is idle, one item at a time.
// Reset clears the valid bits, the owner and the use counter; slot contents
// are not cleared, as they are read only behind a valid bit. The use counter
// is never cleared by a release. req.ready stays low while rst is high.
// When the receiver stalls, the finished result waits in the output
// register and the next request is still accepted and processed; that
// request then waits for the output register to drain before its result is loaded.

module assoc_lru_tag_cache
  import alc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  alc_req_if.sink   req,
  alc_rsp_if.source rsp
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [1:0]            state;
  logic [IDX_W-1:0]      idx;
  logic [SLOTS-1:0]      valid;
  logic [STAMP_W-1:0]    use_count;
  logic [TARGET_W-1:0]   owner;

  // Latched request.
  logic [TARGET_W-1:0]   key_target;
  logic [KEY_ADDR_W-1:0] key_addr;
  logic [DIM_W-1:0]      key_width;
  logic [DIM_W-1:0]      key_height;

  // Result being built.
  logic                  res_hit;
  logic [IDX_W-1:0]      res_idx;
  logic                  res_evicted;
  logic                  res_flushed;

  logic                  accept;
  logic                  last;
  logic                  rsp_load;
  logic [IDX_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      wr_idx;
  logic                  wr_en;
  logic [STAMP_W-1:0]    use_count_next;
  logic                  rel_flush;
  logic                  look_flush;
  slot_entry_t           rd_data;
  slot_entry_t           wr_data;
  scan_ctrl_t            scan_ctrl;
  scan_status_t          scan_status;

  assign req.ready = (state == ST_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign last      = (idx == LAST_IDX);
  assign rsp_load  = (state == ST_RESP) && (!rsp.valid || rsp.ready);

  assign rel_flush  = (req.target_id == '0) || (req.target_id == owner);
  assign look_flush = (owner != '0) && (owner != req.target_id);

  // The read port runs one slot ahead of the compare unit.
  always_comb begin
    if (state == ST_IDLE || last) begin
      rd_idx = '0;
    end else begin
      rd_idx = idx + IDX_W'(1);
    end
  end

  assign scan_ctrl.step  = (state == ST_SCAN);
  assign scan_ctrl.first = (idx == '0);

  assign wr_en          = (state == ST_WRITE);
  assign wr_idx         = res_hit ? res_idx : scan_status.victim;
  assign use_count_next = use_count + STAMP_W'(1);

  assign wr_data.addr   = key_addr;
  assign wr_data.width  = key_width;
  assign wr_data.height = key_height;
  assign wr_data.stamp  = use_count_next;

  alc_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  alc_scan u_scan (
    .clk         (clk),
    .ctrl        (scan_ctrl),
    .idx         (idx),
    .entry       (rd_data),
    .entry_valid (valid[idx]),
    .key_addr    (key_addr),
    .key_width   (key_width),
    .key_height  (key_height),
    .status      (scan_status)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      valid     <= '0;
      use_count <= '0;
      owner     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          if (accept) begin
            if (req.opcode == OP_RELEASE) begin
              if (rel_flush) begin
                valid <= '0;
                owner <= '0;
              end
              state <= ST_RESP;
            end else begin
              if (look_flush) begin
                valid <= '0;
                owner <= '0;
              end
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_status.hit || last) begin
            state <= ST_WRITE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_WRITE: begin
          use_count      <= use_count_next;
          valid[wr_idx]  <= 1'b1;
          if (!res_hit) begin
            owner <= key_target;
          end
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Request key and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_target  <= req.target_id;
      key_addr    <= req.source_address[KEY_ADDR_W-1:0];
      key_width   <= req.image_width;
      key_height  <= req.image_height;
      res_hit     <= 1'b0;
      res_idx     <= '0;
      res_evicted <= 1'b0;
      res_flushed <= (req.opcode == OP_RELEASE) ? rel_flush : look_flush;
    end
    if (state == ST_SCAN && scan_status.hit) begin
      res_hit <= 1'b1;
      res_idx <= idx;
    end
    if (state == ST_WRITE) begin
      res_idx     <= wr_idx;
      res_evicted <= !res_hit && scan_status.victim_valid;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.hit        <= res_hit;
      rsp.slot_index <= slot_code(res_idx);
      rsp.evicted    <= res_evicted;
      rsp.flushed    <= res_flushed;
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for assoc_lru_tag_cache: directed and random lookup and release
// beats, checked against an in-bench LRU tag store model. Depends on alc_pkg and alc_if.
`timescale 1ns / 1ps

module tb;
  import alc_pkg::*;

  // One request beat as queued for the driver. The hold flag makes the driver
  // wait until every outstanding result has drained before offering this beat.
  typedef struct packed {
    logic                  opcode;
    logic [TARGET_W-1:0]   target;
    logic [SRC_ADDR_W-1:0] addr;
    logic [DIM_W-1:0]      width;
    logic [DIM_W-1:0]      height;
    logic                  hold;
  } request_t;

  // One result beat as the cache should produce it.
  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;
    logic                  flushed;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  alc_req_if req_ch ();
  alc_rsp_if rsp_ch ();

  assoc_lru_tag_cache u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Beats waiting to be offered, and results the cache still owes us.
  request_t stim_q[$];
  outcome_t awaited_q[$];
  request_t in_flight;

  int beats_sent = 0;
  int errors     = 0;
  int n_lookups  = 0;
  int n_hits     = 0;
  int n_evicts   = 0;
  int n_releases = 0;
  int n_flushes  = 0;

  // A stretch of a couple hundred beats runs with neither side idling, so
  // the cache is exercised back to back as well as with random gaps.
  logic calm;
  assign calm = (beats_sent >= 300) && (beats_sent < 500);

  // ---------------------------------------------------------------------------
  // Shadow copy of the tag store. Slot keys are compared in the low
  // KEY_ADDR_W bits of the address, the stamps come from one global use
  // counter, and the owner register tells which target the slots belong to.
  // ---------------------------------------------------------------------------
  logic                  shadow_live  [SLOTS];
  logic [KEY_ADDR_W-1:0] shadow_addr  [SLOTS];
  logic [DIM_W-1:0]      shadow_width [SLOTS];
  logic [DIM_W-1:0]      shadow_height[SLOTS];
  logic [STAMP_W-1:0]    shadow_stamp [SLOTS];
  logic [STAMP_W-1:0]    use_count;
  logic [TARGET_W-1:0]   cache_owner;

  function automatic void drop_all_slots();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_live[i]   = 1'b0;
      shadow_addr[i]   = '0;
      shadow_width[i]  = '0;
      shadow_height[i] = '0;
      shadow_stamp[i]  = '0;
    end
    cache_owner = '0;
  endfunction

  // Applies one accepted beat to the shadow store and returns the result the
  // cache must produce for it.
  function automatic outcome_t cache_predict(input request_t r);
    outcome_t              o;
    int                    victim;
    logic [KEY_ADDR_W-1:0] key_addr;
    o        = '0;
    victim   = 0;
    key_addr = r.addr[KEY_ADDR_W-1:0];

    // A release clears everything when it names the owner or names nobody;
    // a release for some other target leaves the store untouched.
    if (r.opcode == OP_RELEASE) begin
      if (r.target == '0 || r.target == cache_owner) begin
        drop_all_slots();
        o.flushed = 1'b1;
      end
      return o;
    end

    // A lookup by a new target evicts the previous owner's slots first.
    // Owner zero means nobody owns the store, so no flush happens then.
    if (cache_owner != '0 && cache_owner != r.target) begin
      drop_all_slots();
      o.flushed = 1'b1;
    end

    // Walk the slots in order. The victim search keeps the last empty slot,
    // or, while every slot seen so far is valid, the first one with the
    // oldest stamp.
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_live[i] && shadow_addr[i] == key_addr &&
          shadow_width[i] == r.width && shadow_height[i] == r.height) begin
        use_count       = use_count + 1'b1;
        shadow_stamp[i] = use_count;
        o.hit           = 1'b1;
        o.slot          = i[SLOT_OUT_W-1:0];
        return o;
      end
      if (!shadow_live[i])
        victim = i;
      else if (shadow_live[victim] && shadow_stamp[i] < shadow_stamp[victim])
        victim = i;
    end

    // Miss: the victim is overwritten and the requester becomes the owner.
    o.slot    = victim[SLOT_OUT_W-1:0];
    o.evicted = shadow_live[victim];
    use_count             = use_count + 1'b1;
    cache_owner           = r.target;
    shadow_live[victim]   = 1'b1;
    shadow_addr[victim]   = key_addr;
    shadow_width[victim]  = r.width;
    shadow_height[victim] = r.height;
    shadow_stamp[victim]  = use_count;
    return o;
  endfunction

  function automatic request_t make_req(input logic op, input logic [TARGET_W-1:0] tgt,
                                        input logic [SRC_ADDR_W-1:0] addr,
                                        input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    request_t r;
    r.opcode = op;
    r.target = tgt;
    r.addr   = addr;
    r.width  = w;
    r.height = h;
    r.hold   = 1'b0;
    return r;
  endfunction

  // Full-width random address; every bit of the 48 gets both values.
  function automatic logic [SRC_ADDR_W-1:0] rand_addr();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[SRC_ADDR_W-1:0];
  endfunction

  // Mismatch reporting: one line per failure, and a running count.
  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    errors++;
    $display("tb: mismatch in %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. A beat that is offered stays on the bus untouched until it
  // is accepted; the expected result is worked out at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : req_driver
    logic taken;
    taken = req_ch.valid && req_ch.ready;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (taken) begin
        awaited_q.push_back(cache_predict(in_flight));
        beats_sent <= beats_sent + 1;
      end
      if (req_ch.valid && !taken) begin
        // Still waiting for the cache to take the current beat.
      end else if (stim_q.size() != 0 && (calm || $urandom_range(99) >= 13) &&
                   !(stim_q[0].hold && (taken || awaited_q.size() != 0))) begin
        in_flight = stim_q.pop_front();
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= in_flight.opcode;
        req_ch.target_id      <= in_flight.target;
        req_ch.source_address <= in_flight.addr;
        req_ch.image_width    <= in_flight.width;
        req_ch.image_height   <= in_flight.height;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. Each accepted result beat is matched against the oldest
  // outstanding expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_monitor
    outcome_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("unexpected result beat", 64'd0, 64'd1);
        end else begin
          want = awaited_q.pop_front();
          if (rsp_ch.hit !== want.hit)
            report_mismatch("hit", want.hit, rsp_ch.hit);
          if (rsp_ch.slot_index !== want.slot)
            report_mismatch("slot_index", want.slot, rsp_ch.slot_index);
          if (rsp_ch.evicted !== want.evicted)
            report_mismatch("evicted", want.evicted, rsp_ch.evicted);
          if (rsp_ch.flushed !== want.flushed)
            report_mismatch("flushed", want.flushed, rsp_ch.flushed);
          n_hits    += want.hit;
          n_evicts  += want.evicted;
          n_flushes += want.flushed;
        end
      end
      rsp_ch.ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    request_t              r;
    request_t              key_pool[10];
    logic [SRC_ADDR_W-1:0] k_addr[10];
    logic [TARGET_W-1:0]   session_tgt;
    int                    pick;
    int                    kk;

    req_ch.valid          = 1'b0;
    req_ch.opcode         = OP_LOOKUP;
    req_ch.target_id      = '0;
    req_ch.source_address = '0;
    req_ch.image_width    = '0;
    req_ch.image_height   = '0;
    rsp_ch.ready          = 1'b0;
    drop_all_slots();
    use_count = '0;

    // Directed part. Releases on an empty store: one for everybody (reports
    // a flush anyway) and one for a target that does not own the store.
    stim_q.push_back(make_req(OP_RELEASE, 16'd0, 48'd1, 16'd1, 16'd1));
    stim_q.push_back(make_req(OP_RELEASE, 16'd5, 48'd1, 16'd1, 16'd1));
    // Extreme keys fill the last empty slots first; the repeat is a hit.
    stim_q.push_back(make_req(OP_LOOKUP, 16'd1, '1, 16'hFFFF, 16'hFFFF));
    stim_q.push_back(make_req(OP_LOOKUP, 16'd1, 48'd1, 16'd1, 16'd1));
    stim_q.push_back(make_req(OP_LOOKUP, 16'd1, '1, 16'hFFFF, 16'hFFFF));
    // A zero address, width and height is just another key.
    stim_q.push_back(make_req(OP_LOOKUP, 16'd1, 48'd0, 16'd0, 16'd0));
    stim_q.push_back(make_req(OP_LOOKUP, 16'd1, 48'd0, 16'd0, 16'd0));
    // A foreign release must leave the slots alone, so the next lookup hits.
    stim_q.push_back(make_req(OP_RELEASE, 16'd2, 48'd0, 16'd0, 16'd0));
    stim_q.push_back(make_req(OP_LOOKUP, 16'd1, 48'd1, 16'd1, 16'd1));
    // A new target flushes; target zero then flushes and leaves no owner,
    // so a later target hits what target zero filled.
    stim_q.push_back(make_req(OP_LOOKUP, 16'd2, 48'h1234_5678_9ABC, 16'd640, 16'd480));
    stim_q.push_back(make_req(OP_LOOKUP, 16'd0, 48'h8000_0000_0000, 16'h8000, 16'h8000));
    stim_q.push_back(make_req(OP_LOOKUP, 16'hFFFF, 48'h8000_0000_0000, 16'h8000, 16'h8000));
    stim_q.push_back(make_req(OP_LOOKUP, 16'hFFFF, 48'h0000_0000_0002, 16'h8000, 16'h8000));
    // A release by the owner clears the store.
    stim_q.push_back(make_req(OP_RELEASE, 16'hFFFF, '1, 16'hFFFF, 16'hFFFF));
    // Fill all eight slots, refresh the first one, then miss twice so the
    // oldest stamps get replaced. The first fill waits for all results to drain.
    for (int j = 0; j < 8; j++) begin
      k_addr[j] = rand_addr();
      r = make_req(OP_LOOKUP, 16'd3, k_addr[j], 16'd100, 16'd200);
      r.hold = (j == 0);
      stim_q.push_back(r);
    end
    stim_q.push_back(make_req(OP_LOOKUP, 16'd3, k_addr[0], 16'd100, 16'd200));
    stim_q.push_back(make_req(OP_LOOKUP, 16'd3, k_addr[0], 16'd101, 16'd200));
    stim_q.push_back(make_req(OP_LOOKUP, 16'd3, k_addr[0], 16'd100, 16'd201));

    // Random part. Most beats are lookups by the current target drawn from a
    // pool of ten keys, which is more than the store holds, so hits, empty
    // fills and LRU evictions all show up. Some odd pool keys share their
    // address with a neighbor and differ only in size. The rest changes
    // owners, releases, or is noise with every field random.
    session_tgt = 16'd1;
    for (int n = 0; n < 1050; n++) begin
      if (n % 200 == 0) begin
        for (int j = 0; j < 10; j++) begin
          key_pool[j] = make_req(OP_LOOKUP, '0, rand_addr(), 16'($urandom),
                                 16'($urandom));
          if (j % 2 == 1 && $urandom_range(1) == 1)
            key_pool[j].addr = key_pool[j-1].addr;
        end
      end
      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0:       session_tgt = 16'd0;
          1:       session_tgt = 16'($urandom);
          default: session_tgt = 16'($urandom_range(4, 1));
        endcase
      end
      pick = $urandom_range(99);
      kk   = $urandom_range(9);
      if (pick < 80) begin
        r = make_req(OP_LOOKUP, session_tgt, key_pool[kk].addr, key_pool[kk].width,
                     key_pool[kk].height);
      end else if (pick < 85) begin
        r = make_req(OP_LOOKUP, 16'($urandom_range(4)), key_pool[kk].addr,
                     key_pool[kk].width, key_pool[kk].height);
      end else if (pick < 89) begin
        r = make_req(OP_RELEASE, ($urandom_range(1) == 1) ? session_tgt : 16'd0,
                     rand_addr(), 16'($urandom), 16'($urandom));
      end else if (pick < 92) begin
        r = make_req(OP_RELEASE, 16'($urandom), rand_addr(), 16'($urandom),
                     16'($urandom));
      end else begin
        r = make_req(1'($urandom), 16'($urandom), rand_addr(), 16'($urandom),
                     16'($urandom));
      end
      // Now and then the sender stops until every result is back.
      r.hold = (n % 250 == 0);
      if (r.opcode == OP_RELEASE)
        n_releases++;
      else
        n_lookups++;
      stim_q.push_back(r);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Sampled on the falling edge so that the driver's updates are settled.
    do
      @(negedge clk);
    while (stim_q.size() != 0 || req_ch.valid || awaited_q.size() != 0);
    // Give a stray extra result time to show up.
    repeat (40) @(posedge clk);

    $display("tb: %0d beats sent: %0d random lookups, %0d random releases, plus the directed set",
             beats_sent, n_lookups, n_releases);
    $display("tb: observed %0d hits, %0d evictions, %0d flushes, %0d mismatches",
             n_hits, n_evicts, n_flushes, errors);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: a correct run takes well under a tenth of this.
  initial begin : watchdog
    #2_000_000;
    $display("tb: timeout with %0d beats sent, %0d results outstanding",
             beats_sent, awaited_q.size());
    $display("tb: FAIL");
    $finish;
  end

endmodule
